>>> sv/multi_channel_led_blinker_core_macros.svh
// Assertion macros for the LED blinker checker.
// Plain text macros, no dependencies.
`ifndef MULTI_CHANNEL_LED_BLINKER_CORE_MACROS_SVH
`define MULTI_CHANNEL_LED_BLINKER_CORE_MACROS_SVH

// Clocked assertion with asynchronous reset disable.
`define MCLB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mclb assertion failed");

// Condition in one cycle implies a condition in the next.
`define MCLB_ASSERT_NEXT(label, clk, rst_n, cond, expect_next) \
    `MCLB_ASSERT(label, clk, rst_n, (cond) |=> (expect_next))

`endif

>>> sv/mclb_pkg.sv
// Shared types and constants of the LED blinker core.
// No dependencies.
package mclb_pkg;

    localparam int MCLB_CHANNELS  = 8;
    localparam int CNT_W          = 16;
    localparam int PRESCALE_W     = 9;
    localparam int TICK_W         = 8;
    localparam int CHAN_W         = 3;
    localparam int PIN_W          = 8;
    localparam int IN_DATA_W      = 56;
    localparam int OUT_DATA_W     = 16;
    localparam logic [PRESCALE_W-1:0] PRESCALE_MAX = 9'd256;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_STEP,
        OP_PROG
    } mclb_op_t;

    // payload walking down the cell chain
    typedef struct packed {
        mclb_op_t           op;
        logic [CHAN_W-1:0]  channel;
        logic [CNT_W-1:0]   on_time;
        logic [CNT_W-1:0]   off_time;
        logic [CNT_W-1:0]   blink_count;
        logic               active_high;
        logic [PIN_W-1:0]   pins;
        logic [PIN_W-1:0]   done;
    } mclb_tok_t;

endpackage

>>> sv/mclb_prescaler.sv
// Tick prescaler: holds the prescale register and the raw tick counter.
// Depends on mclb_pkg.
module mclb_prescaler
    import mclb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr,
    input  logic [PRESCALE_W-1:0] cfg_data,
    input  logic                  tick,
    output logic                  step
);

    logic [PRESCALE_W-1:0] prescale_reg;
    logic [TICK_W-1:0]     tick_count_reg;
    logic [TICK_W-1:0]     tick_count_next;
    logic [PRESCALE_W-1:0] period;
    logic [PRESCALE_W-1:0] count_plus;

    // zero acts as 1, anything above 256 as 256
    always_comb
    begin
        if (prescale_reg == '0)
            period = PRESCALE_W'(1);
        else if (prescale_reg > PRESCALE_MAX)
            period = PRESCALE_MAX;
        else
            period = prescale_reg;
    end

    assign count_plus = PRESCALE_W'(tick_count_reg) + PRESCALE_W'(1);
    assign step       = (count_plus >= period);

    always_comb
    begin
        tick_count_next = tick_count_reg;
        if (tick)
            tick_count_next = step ? '0 : tick_count_reg + TICK_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg   <= PRESCALE_W'(1);
            tick_count_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
                prescale_reg <= cfg_data;
            tick_count_reg <= tick_count_next;
        end
    end

endmodule

>>> sv/mclb_cell.sv
// One channel cell: channel state plus one chain register stage.
// Depends on mclb_pkg.
module mclb_cell
    import mclb_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      tok_valid_in,
    input  mclb_tok_t tok_in,
    output logic      tok_valid_out,
    output mclb_tok_t tok_out
);

    logic [CNT_W-1:0] on_len_reg, on_len_next;
    logic [CNT_W-1:0] off_len_reg, off_len_next;
    logic [CNT_W-1:0] on_rem_reg, on_rem_next;
    logic [CNT_W-1:0] off_rem_reg, off_rem_next;
    logic [CNT_W-1:0] blinks_reg, blinks_next;
    logic             forever_reg, forever_next;
    logic             running_reg, running_next;
    logic             pol_reg, pol_next;
    logic             lit_reg, lit_next;
    logic             done;
    logic             on_zero;
    logic             both_zero;
    logic             do_step;
    logic             do_prog;
    logic             tok_valid_reg;
    mclb_tok_t        tok_reg, tok_next;

    assign do_step   = tok_valid_in && (tok_in.op == OP_STEP) && running_reg;
    assign do_prog   = tok_valid_in && (tok_in.op == OP_PROG)
                       && (int'(tok_in.channel) == INDEX);
    assign on_zero   = (on_rem_reg == '0);
    assign both_zero = on_zero && (off_rem_reg == '0);

    always_comb
    begin
        on_len_next  = on_len_reg;
        off_len_next = off_len_reg;
        on_rem_next  = on_rem_reg;
        off_rem_next = off_rem_reg;
        blinks_next  = blinks_reg;
        forever_next = forever_reg;
        running_next = running_reg;
        pol_next     = pol_reg;
        lit_next     = lit_reg;
        done         = 1'b0;
        if (do_prog)
        begin
            pol_next     = tok_in.active_high;
            on_len_next  = tok_in.on_time;
            on_rem_next  = tok_in.on_time;
            off_len_next = tok_in.off_time;
            off_rem_next = tok_in.off_time;
            forever_next = (tok_in.blink_count == '0);
            blinks_next  = (tok_in.blink_count == '0) ? '0
                                                      : tok_in.blink_count - CNT_W'(1);
            running_next = (tok_in.on_time != '0);
            lit_next     = (tok_in.on_time != '0);
        end
        else if (do_step)
        begin
            // toggle at end of lit phase or at blink boundary
            if (on_zero && ((off_rem_reg == off_len_reg) || both_zero))
                lit_next = !lit_reg;
            if (both_zero)
            begin
                if (!forever_reg && (blinks_reg == '0))
                begin
                    lit_next     = 1'b0;
                    running_next = 1'b0;
                    done         = 1'b1;
                end
                else
                begin
                    on_rem_next  = on_len_reg;
                    off_rem_next = off_len_reg;
                    if (!forever_reg)
                        blinks_next = blinks_reg - CNT_W'(1);
                end
            end
            if (running_next)
            begin
                if (on_rem_next != '0)
                    on_rem_next = on_rem_next - CNT_W'(1);
                else
                    off_rem_next = off_rem_next - CNT_W'(1);
            end
        end
    end

    // report this channel's pin and done bits, only the first eight fit
    generate
        if (INDEX < PIN_W)
        begin : g_report
            always_comb
            begin
                tok_next             = tok_in;
                tok_next.pins[INDEX] = (lit_next == pol_next);
                tok_next.done[INDEX] = done;
            end
        end
        else
        begin : g_silent
            always_comb
            begin
                tok_next = tok_in;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            pol_reg       <= 1'b0;
            lit_reg       <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            running_reg   <= running_next;
            pol_reg       <= pol_next;
            lit_reg       <= lit_next;
            tok_valid_reg <= tok_valid_in;
        end
    end

    // counters matter only while running, and a program loads them all
    always_ff @(posedge clk)
    begin
        on_len_reg  <= on_len_next;
        off_len_reg <= off_len_next;
        on_rem_reg  <= on_rem_next;
        off_rem_reg <= off_rem_next;
        blinks_reg  <= blinks_next;
        forever_reg <= forever_next;
        tok_reg     <= tok_next;
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

>>> sv/multi_channel_led_blinker_core.sv
// Multi-channel LED blinker core: one cell per channel, chained, plus the
// tick prescaler and the result register. Depends on mclb_pkg, mclb_prescaler
// and mclb_cell.
//
// Each input item is either a tick (tuser = 0) or a channel program (tuser = 1)
// and produces exactly one result item holding every pin level and the mask
// of channels that finished their last blink on that item. An accepted item
// launches a token into a row of CHANNELS cells; each cell owns one channel's
// counters, applies the program or the blink step to itself and stamps its
// pin and done bits into the token, which moves one cell per clock. The first
// cell registers the token at the accepting edge, and the token then passes
// the remaining CHANNELS - 1 cells and the output register before m_tvalid
// rises. The core handles one item at a time: s_tready drops at acceptance
// and returns the cycle after the result is taken. The prescale register is
// written through cfg_valid/cfg_data, always ready; write it only while the
// core is idle. Prescale 0 acts as 1, values above 256 act as 256.
// Only channels 0 to 7 appear on the result; programs naming a missing channel
// change nothing.
module multi_channel_led_blinker_core
    import mclb_pkg::*;
#(
    parameter int CHANNELS = MCLB_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration: prescale register
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [PRESCALE_W-1:0] cfg_data,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [2:0] channel, [18:3] on_time, [34:19] off_time, [50:35] blink_count,
    // [51] active_high, [55:52] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [0] mode
    input  logic [0:0]            s_tuser,
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] pin_levels, [15:8] finished
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic                  in_accept;
    logic                  out_accept;
    logic                  tick;
    logic                  step;
    logic                  busy_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic      tok_valid [CHANNELS+1];
    mclb_tok_t tok       [CHANNELS+1];

    assign cfg_ready  = 1'b1;
    assign s_tready   = !busy_reg;
    assign in_accept  = s_tvalid && s_tready;
    assign out_accept = m_tvalid_reg && m_tready;
    assign tick       = in_accept && !s_tuser[0];

    mclb_prescaler u_prescaler (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .tick     (tick),
        .step     (step)
    );

    // launch token: unpack the item, start with empty pin and done vectors
    always_comb
    begin
        tok_valid[0]        = in_accept;
        tok[0].channel      = s_tdata[2:0];
        tok[0].on_time      = s_tdata[18:3];
        tok[0].off_time     = s_tdata[34:19];
        tok[0].blink_count  = s_tdata[50:35];
        tok[0].active_high  = s_tdata[51];
        tok[0].pins         = '0;
        tok[0].done         = '0;
        if (s_tuser[0])
            tok[0].op = OP_PROG;
        else if (step)
            tok[0].op = OP_STEP;
        else
            tok[0].op = OP_NOP;
    end

    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++)
        begin : g_cell
            mclb_cell #(
                .INDEX (g)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .tok_valid_in  (tok_valid[g]),
                .tok_in        (tok[g]),
                .tok_valid_out (tok_valid[g+1]),
                .tok_out       (tok[g+1])
            );
        end
    endgenerate

    // busy from acceptance until the result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                busy_reg <= 1'b1;
            else if (out_accept)
                busy_reg <= 1'b0;

            if (tok_valid[CHANNELS])
                m_tvalid_reg <= 1'b1;
            else if (out_accept)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_valid[CHANNELS])
            m_tdata_reg <= {tok[CHANNELS].done, tok[CHANNELS].pins};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> sv/mclb_checker.sv
// Port-level checker for the LED blinker core, bound to the top level.
// Depends on mclb_pkg and multi_channel_led_blinker_core_macros.svh.
`include "multi_channel_led_blinker_core_macros.svh"

module mclb_checker
    import mclb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // stalled result holds
    `MCLB_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // one item in flight: no new item right after acceptance
    `MCLB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // the result passes the whole cell chain, no stale result behind an accept
    `MCLB_ASSERT_NEXT(a_no_early_result, clk, rst_n, s_tvalid && s_tready, !m_tvalid)
    // taking the result frees the input side
    `MCLB_ASSERT_NEXT(a_ready_after_take, clk, rst_n, m_tvalid && m_tready, s_tready && !m_tvalid)

endmodule

bind multi_channel_led_blinker_core mclb_checker u_mclb_checker (.*);

>>> verif/multi_channel_led_blinker_core_tb.sv
// Self-checking testbench for multi_channel_led_blinker_core: ticks and channel
// programs go in over the stream port, pin levels and finished masks are checked
// against a predictor kept in a small scoreboard class. Depends on mclb_pkg.
module tb
    import mclb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam bit MODE_TICK = 1'b0;
    localparam bit MODE_PROG = 1'b1;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 800000;
    // long receiver hold-off, started once this many results have been checked
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 2 * (MCLB_CHANNELS + 2);

    // one input item as the sender sees it
    typedef struct {
        logic               mode;
        logic [CHAN_W-1:0]  channel;
        logic [CNT_W-1:0]   on_time;
        logic [CNT_W-1:0]   off_time;
        logic [CNT_W-1:0]   blink_count;
        logic               active_high;
    } blink_cmd_t;

    // result item, laid out as on m_tdata
    typedef struct packed {
        logic [PIN_W-1:0] finished;
        logic [PIN_W-1:0] pins;
    } blink_result_t;

    // Tracks every channel's blink counters and the prescaler, predicts the
    // result of each accepted item and compares the results that come back.
    class blink_scoreboard;
        logic [CNT_W-1:0]      on_len   [MCLB_CHANNELS];
        logic [CNT_W-1:0]      off_len  [MCLB_CHANNELS];
        logic [CNT_W-1:0]      on_rem   [MCLB_CHANNELS];
        logic [CNT_W-1:0]      off_rem  [MCLB_CHANNELS];
        logic [CNT_W-1:0]      left     [MCLB_CHANNELS];
        bit                    endless  [MCLB_CHANNELS];
        bit                    running  [MCLB_CHANNELS];
        bit                    pol_high [MCLB_CHANNELS];
        bit                    lit      [MCLB_CHANNELS];
        logic [TICK_W-1:0]     tick_cnt;
        logic [PRESCALE_W-1:0] prescale;
        blink_result_t         expected_results[$];
        int                    mismatches;
        int                    results_seen;
        int                    finish_events;

        function new();
            for (int i = 0; i < MCLB_CHANNELS; i++)
            begin
                on_len[i]   = '0;
                off_len[i]  = '0;
                on_rem[i]   = '0;
                off_rem[i]  = '0;
                left[i]     = '0;
                endless[i]  = 1'b0;
                running[i]  = 1'b0;
                pol_high[i] = 1'b0;
                lit[i]      = 1'b0;
            end
            tick_cnt      = '0;
            prescale      = PRESCALE_W'(1);
            mismatches    = 0;
            results_seen  = 0;
            finish_events = 0;
        endfunction

        function void set_prescale(logic [PRESCALE_W-1:0] value);
            prescale = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // one blink step of one channel; returns 1 when it ends its last blink
        function bit advance(int ch);
            bit done;
            done = 1'b0;
            if (!running[ch])
                return 1'b0;
            if (on_rem[ch] == 0 && (off_rem[ch] == off_len[ch] || off_rem[ch] == 0))
            begin
                lit[ch] = !lit[ch];
                if (off_rem[ch] == 0)
                begin
                    if (!endless[ch] && left[ch] == 0)
                    begin
                        lit[ch]     = 1'b0;
                        running[ch] = 1'b0;
                        done        = 1'b1;
                    end
                    else
                    begin
                        on_rem[ch]  = on_len[ch];
                        off_rem[ch] = off_len[ch];
                        if (!endless[ch])
                            left[ch] = left[ch] - 1'b1;
                    end
                end
            end
            if (running[ch])
            begin
                if (on_rem[ch] != 0)
                    on_rem[ch] = on_rem[ch] - 1'b1;
                else
                    off_rem[ch] = off_rem[ch] - 1'b1;
            end
            return done;
        endfunction

        function void note_item(blink_cmd_t cmd);
            blink_result_t want;
            int            period;
            int            ch;
            want = '0;
            if (cmd.mode == MODE_PROG)
            begin
                ch = cmd.channel;
                if (ch < MCLB_CHANNELS)
                begin
                    pol_high[ch] = cmd.active_high;
                    on_len[ch]   = cmd.on_time;
                    on_rem[ch]   = cmd.on_time;
                    off_len[ch]  = cmd.off_time;
                    off_rem[ch]  = cmd.off_time;
                    endless[ch]  = (cmd.blink_count == 0);
                    left[ch]     = (cmd.blink_count == 0) ? '0 : cmd.blink_count - 1'b1;
                    running[ch]  = (cmd.on_time != 0);
                    lit[ch]      = (cmd.on_time != 0);
                end
            end
            else
            begin
                // zero acts as one, anything past 256 as 256
                period = prescale;
                if (period == 0)
                    period = 1;
                if (period > 256)
                    period = 256;
                if (int'(tick_cnt) + 1 >= period)
                begin
                    tick_cnt = '0;
                    for (int i = 0; i < MCLB_CHANNELS; i++)
                        if (advance(i) && i < PIN_W)
                            want.finished[i] = 1'b1;
                end
                else
                    tick_cnt = tick_cnt + 1'b1;
            end
            for (int i = 0; i < MCLB_CHANNELS && i < PIN_W; i++)
                want.pins[i] = (lit[i] == pol_high[i]);
            expected_results.push_back(want);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            blink_result_t got;
            blink_result_t want;
            got = data;
            results_seen++;
            if (got.finished != 0)
                finish_events++;
            if (expected_results.size() == 0)
            begin
                flag($sformatf("result %h with nothing expected", data));
                return;
            end
            want = expected_results.pop_front();
            if (got.pins != want.pins)
                flag($sformatf("result %0d pin_levels: expected %h, got %h",
                               results_seen, want.pins, got.pins));
            if (got.finished != want.finished)
                flag($sformatf("result %0d finished: expected %h, got %h",
                               results_seen, want.finished, got.finished));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [PRESCALE_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    blink_scoreboard board = new();
    int  items_sent  = 0;
    int  cycle_count = 0;
    bit  steady_src  = 1'b0;
    bit  steady_sink = 1'b0;
    bit  hold_done   = 1'b0;

    multi_channel_led_blinker_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, board.pending());
            $display("multi_channel_led_blinker_core regression: fail");
            $finish;
        end
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int idle_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic blink_cmd_t prog_cmd(int ch, int on_t, int off_t, int cnt, bit ah);
        blink_cmd_t cmd;
        cmd.mode        = MODE_PROG;
        cmd.channel     = CHAN_W'(ch);
        cmd.on_time     = CNT_W'(on_t);
        cmd.off_time    = CNT_W'(off_t);
        cmd.blink_count = CNT_W'(cnt);
        cmd.active_high = ah;
        return cmd;
    endfunction

    function automatic blink_cmd_t tick_cmd();
        blink_cmd_t cmd;
        cmd.mode        = MODE_TICK;
        cmd.channel     = CHAN_W'($urandom);
        cmd.on_time     = CNT_W'($urandom);
        cmd.off_time    = CNT_W'($urandom);
        cmd.blink_count = CNT_W'($urandom);
        cmd.active_high = 1'($urandom);
        return cmd;
    endfunction

    // Programs mostly use short timings and counts so that blinks finish
    // within a phase; a few carry full-range values to exercise every bit.
    function automatic blink_cmd_t random_cmd(int prog_pct);
        if ($urandom_range(0, 99) >= prog_pct)
            return tick_cmd();
        if ($urandom_range(0, 99) < 85)
            return prog_cmd($urandom_range(0, MCLB_CHANNELS - 1), $urandom_range(0, 6),
                            $urandom_range(0, 6), $urandom_range(0, 4), 1'($urandom));
        return prog_cmd($urandom_range(0, MCLB_CHANNELS - 1), $urandom, $urandom,
                        $urandom, 1'($urandom));
    endfunction

    // Offer one item and hold it until the core takes it. valid stays high
    // afterwards so back-to-back items need no second assignment.
    task automatic send_item(input blink_cmd_t cmd);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd.mode;
        s_tdata  <= {4'b0, cmd.active_high, cmd.blink_count, cmd.off_time,
                     cmd.on_time, cmd.channel};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_item(cmd);
        items_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    // stop offering and wait until every predicted result has been checked
    task automatic drain();
        pause_sender(1);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    // prescale write, only issued while the core is idle
    task automatic write_prescale(input logic [PRESCALE_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_prescale(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: ready runs broken by random stalls, plus one long hold-off
    // once traffic is flowing so the core backs up and drops s_tready.
    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_gap(steady_sink);
            if (!hold_done && board.results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                stall     = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1)
                    @(negedge clk);
            end
            repeat ($urandom_range(1, 16))
            begin
                @(negedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);

    // Phases of random traffic, one prescale setting each. The 256 phase is
    // nearly all ticks so at least one blink step lands in it; 0 and 511
    // cover the clamped settings.
    typedef struct {
        logic [PRESCALE_W-1:0] prescale;
        int                    count;
        int                    prog_pct;
        bit                    src_steady;
        bit                    sink_steady;
    } phase_t;

    phase_t phases[6] = '{
        '{9'd0,   110, 25, 1'b0, 1'b0},
        '{9'd3,   150, 20, 1'b0, 1'b0},
        '{9'd1,   150, 30, 1'b1, 1'b1},
        '{9'd256, 280,  4, 1'b0, 1'b0},
        '{9'd511,  60, 10, 1'b0, 1'b0},
        '{9'd2,   100, 25, 1'b0, 1'b1}
    };

    initial
    begin : stimulus
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_TICK;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset prescale of one: idle pins read high,
        // extremes of every field, a stopped channel (zero on time), zero off
        // time, blink forever, and reprogramming a channel mid-blink.
        send_item(tick_cmd());
        send_item(prog_cmd(0, 1, 1, 2, 1'b1));
        send_item(prog_cmd(1, 2, 0, 3, 1'b0));
        send_item(prog_cmd(7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_item(prog_cmd(2, 0, 5, 1, 1'b1));
        send_item(prog_cmd(3, 1, 2, 0, 1'b0));
        repeat (8)
            send_item(tick_cmd());
        send_item(prog_cmd(0, 3, 1, 1, 1'b0));
        repeat (6)
            send_item(tick_cmd());
        send_item(prog_cmd(7, 0, 0, 0, 1'b0));
        repeat (2)
            send_item(tick_cmd());
        drain();

        foreach (phases[p])
        begin
            write_prescale(phases[p].prescale);
            steady_src  = phases[p].src_steady;
            steady_sink = phases[p].sink_steady;
            for (int n = 0; n < phases[p].count; n++)
            begin
                send_item(random_cmd(phases[p].prog_pct));
                pause_sender(idle_gap(steady_src));
            end
            drain();
        end

        repeat (SETTLE)
            @(posedge clk);
        if (board.pending() != 0)
            board.flag($sformatf("%0d results never arrived", board.pending()));

        $display("%0d items sent, %0d results checked, %0d with a finished flag",
                 items_sent, board.results_seen, board.finish_events);
        $display("prescale settings 1, 0, 3, 1, 256, 511, 2; %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0)
            $display("multi_channel_led_blinker_core regression: pass");
        else
            $display("multi_channel_led_blinker_core regression: fail");
        $finish;
    end

endmodule
